>>> rtl/core/rsd_pkg.sv
// types, constants and case codes shared by the rectangle separation block
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int COORD_BITS    = 12;
    localparam int SIZE_BITS     = COORD_BITS + 1;
    localparam int EDGE_BITS     = COORD_BITS + 2;
    localparam int FRACTION_BITS = 8;
    localparam int CAP_BITS      = 27;
    localparam int SEP_BITS      = 21;
    localparam int SQ_BITS       = 2 * EDGE_BITS;
    localparam int DIST_BITS     = SQ_BITS + 1;
    localparam int MIN_BITS      = (DIST_BITS > CAP_BITS) ? DIST_BITS : CAP_BITS;
    localparam int ROOT_BITS     = (CAP_BITS + 2 * FRACTION_BITS + 1) / 2;
    localparam int RAD_BITS      = 2 * ROOT_BITS;
    localparam int REM_BITS      = ROOT_BITS + 2;
    localparam int GAP_Q_BITS    = COORD_BITS + FRACTION_BITS;
    localparam int SAT_BITS_A    = (ROOT_BITS > GAP_Q_BITS) ? ROOT_BITS : GAP_Q_BITS;
    localparam int SAT_BITS      = (SAT_BITS_A > SEP_BITS) ? SAT_BITS_A : SEP_BITS;
    localparam int CORNER_PAIRS  = 16;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(10000);
    localparam logic [SEP_BITS-1:0] SEP_MAX   = '1;

    typedef enum logic [1:0] {
        CASE_OVERLAP    = 2'd0,
        CASE_VERTICAL   = 2'd1,
        CASE_HORIZONTAL = 2'd2,
        CASE_CORNER     = 2'd3
    } case_code_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [SIZE_BITS-1:0]  first_width;
        logic [SIZE_BITS-1:0]  first_height;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
        logic [SIZE_BITS-1:0]  second_width;
        logic [SIZE_BITS-1:0]  second_height;
    } rect_pair_t;

    typedef struct packed {
        logic [SEP_BITS-1:0] separation_q8;
        case_code_t          case_code;
    } separation_t;

endpackage

>>> rtl/core/rect_separation_distance.sv
// rectangle separation: pipelined overlap test, corner search and square root
//
//   channel | direction | handshake          | beat
//   rect    | in        | rect_valid/stall   | rect_pair_t, two rectangles
//   sep     | out       | sep_valid/stall    | separation_t, gap and case code
//   cfg     | in        | cfg_we             | squared distance cap, 27 bits
//
// one beat enters per cycle while rect_stall is low; sep_valid rises once the beat has passed
// the 8 front stages and one square root stage per root bit, then the output register
// reset clears all valid bits and loads the cap with 10000
// a skid register behind the output takes one more result while sep is stalled;
// rect_stall is raised only while that skid register is full
`timescale 1ns / 1ps

module rect_separation_distance (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rect_valid,
    output logic                        rect_stall,
    input  rsd_pkg::rect_pair_t         rect,
    output logic                        sep_valid,
    input  logic                        sep_stall,
    output rsd_pkg::separation_t        sep,
    input  logic                        cfg_we,
    input  logic [rsd_pkg::CAP_BITS-1:0] cfg_wdata
);
    import rsd_pkg::*;

    localparam int FRONT = 8;
    localparam int PIPE  = FRONT + ROOT_BITS;
    localparam int LAST  = PIPE - 1;

    typedef struct packed {
        case_code_t            code;
        logic [COORD_BITS-1:0] gap;
    } side_t;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        logic [RAD_BITS-1:0]  rad;
    } sqrt_stage_t;

    function automatic logic [EDGE_BITS-1:0] abs_diff(input logic [EDGE_BITS-1:0] p,
                                                      input logic [EDGE_BITS-1:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    // gap from one span to the other, clipped at zero
    function automatic logic [COORD_BITS-1:0] gap_of(input logic [COORD_BITS-1:0] a,
                                                     input logic [EDGE_BITS-1:0]  ea,
                                                     input logic [COORD_BITS-1:0] b,
                                                     input logic [EDGE_BITS-1:0]  eb);
        logic [EDGE_BITS:0] d;
        if (b > a)
        begin
            d = {3'b000, b} - {1'b0, ea};
        end
        else
        begin
            d = {3'b000, a} - {1'b0, eb};
        end
        return d[EDGE_BITS] ? '0 : d[COORD_BITS-1:0];
    endfunction

    function automatic logic [DIST_BITS-1:0] min2(input logic [DIST_BITS-1:0] a,
                                                  input logic [DIST_BITS-1:0] b);
        return (b < a) ? b : a;
    endfunction

    // one restoring square root step, one result bit
    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
        logic [REM_BITS-1:0] acc;
        logic [REM_BITS-1:0] trial;
        sqrt_stage_t         r;
        acc   = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
        trial = {s.root, 2'b01};
        r.rad = s.rad << 2;
        if (acc >= trial)
        begin
            r.rem  = acc - trial;
            r.root = {s.root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem  = acc;
            r.root = {s.root[ROOT_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [CAP_BITS-1:0]   cap_reg;
    logic [PIPE-1:0]       vld_reg;
    logic                  en;

    // stage 0: right and bottom edges
    logic [COORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [EDGE_BITS-1:0]  ex1_reg, ey1_reg, ex2_reg, ey2_reg;
    logic                  w1nz_reg, h1nz_reg, w2nz_reg, h2nz_reg;

    // stage 1: case decision, gap, corner differences
    side_t                 side_next;
    side_t                 side_reg [1:LAST];
    logic [EDGE_BITS-1:0]  dx_next [4];
    logic [EDGE_BITS-1:0]  dy_next [4];
    logic [EDGE_BITS-1:0]  dx_reg  [4];
    logic [EDGE_BITS-1:0]  dy_reg  [4];

    // stage 2 to 7: squares, sums, minimum tree, cap
    logic [SQ_BITS-1:0]    sqx_reg [4];
    logic [SQ_BITS-1:0]    sqy_reg [4];
    logic [DIST_BITS-1:0]  d_next  [CORNER_PAIRS];
    logic [DIST_BITS-1:0]  d_reg   [CORNER_PAIRS];
    logic [DIST_BITS-1:0]  t8_reg  [8];
    logic [DIST_BITS-1:0]  t4_reg  [4];
    logic [DIST_BITS-1:0]  t2_reg  [2];
    logic [DIST_BITS-1:0]  dmin_next;
    logic [CAP_BITS-1:0]   m_next;
    logic [CAP_BITS-1:0]   m_reg;

    // square root stages
    sqrt_stage_t           sq_in  [ROOT_BITS];
    sqrt_stage_t           sq_reg [ROOT_BITS];

    // output
    logic [SAT_BITS-1:0]   wide_next;
    separation_t           result_next;
    separation_t           out_reg;
    separation_t           skid_reg;
    logic                  out_vld_reg;
    logic                  skid_vld_reg;
    logic                  out_take;

    assign en         = !skid_vld_reg;
    assign rect_stall = skid_vld_reg;
    assign sep_valid  = out_vld_reg;
    assign sep        = out_reg;
    assign out_take   = out_vld_reg && !sep_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE-2:0], rect_valid};
        end
    end

    always_comb
    begin
        logic ox;
        logic oy;
        logic [EDGE_BITS-1:0] ax [2];
        logic [EDGE_BITS-1:0] ay [2];
        logic [EDGE_BITS-1:0] bx [2];
        logic [EDGE_BITS-1:0] by [2];
        ox = w1nz_reg && w2nz_reg && (ex1_reg > EDGE_BITS'(x2_reg))
             && (ex2_reg > EDGE_BITS'(x1_reg));
        oy = h1nz_reg && h2nz_reg && (ey1_reg > EDGE_BITS'(y2_reg))
             && (ey2_reg > EDGE_BITS'(y1_reg));
        if (ox && oy)
        begin
            side_next.code = CASE_OVERLAP;
            side_next.gap  = '0;
        end
        else if (ox)
        begin
            side_next.code = CASE_VERTICAL;
            side_next.gap  = gap_of(y1_reg, ey1_reg, y2_reg, ey2_reg);
        end
        else if (oy)
        begin
            side_next.code = CASE_HORIZONTAL;
            side_next.gap  = gap_of(x1_reg, ex1_reg, x2_reg, ex2_reg);
        end
        else
        begin
            side_next.code = CASE_CORNER;
            side_next.gap  = '0;
        end
        ax[0] = EDGE_BITS'(x1_reg);
        ax[1] = ex1_reg;
        ay[0] = EDGE_BITS'(y1_reg);
        ay[1] = ey1_reg;
        bx[0] = EDGE_BITS'(x2_reg);
        bx[1] = ex2_reg;
        by[0] = EDGE_BITS'(y2_reg);
        by[1] = ey2_reg;
        for (int n = 0; n < 4; n++)
        begin
            dx_next[n] = abs_diff(ax[n / 2], bx[n % 2]);
            dy_next[n] = abs_diff(ay[n / 2], by[n % 2]);
        end
    end

    // pair index bits: first x corner, first y corner, second x corner, second y corner
    always_comb
    begin
        logic [3:0] nb;
        for (int n = 0; n < CORNER_PAIRS; n++)
        begin
            nb        = 4'(n);
            d_next[n] = {1'b0, sqx_reg[{nb[3], nb[1]}]} + {1'b0, sqy_reg[{nb[2], nb[0]}]};
        end
    end

    always_comb
    begin
        dmin_next = min2(t2_reg[0], t2_reg[1]);
        m_next    = (MIN_BITS'(dmin_next) < MIN_BITS'(cap_reg))
                    ? CAP_BITS'(dmin_next) : cap_reg;
    end

    always_comb
    begin
        sq_in[0].rem  = '0;
        sq_in[0].root = '0;
        sq_in[0].rad  = RAD_BITS'(m_reg) << (2 * FRACTION_BITS);
        for (int k = 1; k < ROOT_BITS; k++)
        begin
            sq_in[k] = sq_reg[k - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= rect.first_x;
            y1_reg   <= rect.first_y;
            x2_reg   <= rect.second_x;
            y2_reg   <= rect.second_y;
            ex1_reg  <= EDGE_BITS'(rect.first_x) + EDGE_BITS'(rect.first_width);
            ey1_reg  <= EDGE_BITS'(rect.first_y) + EDGE_BITS'(rect.first_height);
            ex2_reg  <= EDGE_BITS'(rect.second_x) + EDGE_BITS'(rect.second_width);
            ey2_reg  <= EDGE_BITS'(rect.second_y) + EDGE_BITS'(rect.second_height);
            w1nz_reg <= (rect.first_width != '0);
            h1nz_reg <= (rect.first_height != '0);
            w2nz_reg <= (rect.second_width != '0);
            h2nz_reg <= (rect.second_height != '0);

            side_reg[1] <= side_next;
            for (int i = 2; i <= LAST; i++)
            begin
                side_reg[i] <= side_reg[i - 1];
            end

            for (int n = 0; n < 4; n++)
            begin
                dx_reg[n]  <= dx_next[n];
                dy_reg[n]  <= dy_next[n];
                sqx_reg[n] <= SQ_BITS'(dx_reg[n]) * SQ_BITS'(dx_reg[n]);
                sqy_reg[n] <= SQ_BITS'(dy_reg[n]) * SQ_BITS'(dy_reg[n]);
            end

            for (int n = 0; n < CORNER_PAIRS; n++)
            begin
                d_reg[n] <= d_next[n];
            end
            for (int n = 0; n < 8; n++)
            begin
                t8_reg[n] <= min2(d_reg[2 * n], d_reg[2 * n + 1]);
            end
            for (int n = 0; n < 4; n++)
            begin
                t4_reg[n] <= min2(t8_reg[2 * n], t8_reg[2 * n + 1]);
            end
            for (int n = 0; n < 2; n++)
            begin
                t2_reg[n] <= min2(t4_reg[2 * n], t4_reg[2 * n + 1]);
            end
            m_reg <= m_next;

            for (int k = 0; k < ROOT_BITS; k++)
            begin
                sq_reg[k] <= sqrt_step(sq_in[k]);
            end
        end
    end

    always_comb
    begin
        case (side_reg[LAST].code)
            CASE_OVERLAP:    wide_next = '0;
            CASE_VERTICAL,
            CASE_HORIZONTAL: wide_next = SAT_BITS'(side_reg[LAST].gap) << FRACTION_BITS;
            CASE_CORNER:     wide_next = SAT_BITS'(sq_reg[ROOT_BITS - 1].root);
            default:         wide_next = '0;
        endcase
        result_next.case_code     = side_reg[LAST].code;
        result_next.separation_q8 = (wide_next > SAT_BITS'(SEP_MAX))
                                    ? SEP_MAX : SEP_BITS'(wide_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_take)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (vld_reg[LAST])
        begin
            out_vld_reg <= 1'b1;
            if (out_vld_reg && !out_take)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // skid holds one beat while the output register waits
    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (vld_reg[LAST])
        begin
            if (!out_vld_reg || out_take)
            begin
                out_reg <= result_next;
            end
            else
            begin
                skid_reg <= result_next;
            end
        end
    end

endmodule
